@@ rtl/base64url_length_checked_decoder_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef BASE64URL_LENGTH_CHECKED_DECODER_DEFINES_SVH
`define BASE64URL_LENGTH_CHECKED_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define B64D_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define B64D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/b64d_pkg.sv @@
`default_nettype none

package b64d_pkg;

  // Byte counter sized for the largest limit
  localparam int unsigned MAX_BYTES = 64;
  typedef logic [6:0] count_t;
  localparam count_t MAX_LIMIT      = count_t'(MAX_BYTES);
  localparam count_t EXPECTED_RESET = 7'd32;

  // Alphabet offsets
  localparam logic [5:0] LOWER_BASE = 6'd26;
  localparam logic [5:0] DIGIT_BASE = 6'd52;
  localparam logic [5:0] DASH_CODE  = 6'd62;
  localparam logic [5:0] USCORE_CODE = 6'd63;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_TOO_MANY = 2'd2,
    ST_TOO_FEW  = 2'd3
  } status_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  // Per-message decoder state
  typedef struct packed {
    logic [11:0] acc;
    logic [3:0]  pend;
    count_t      count;
    status_t     err;
  } msg_state_t;

  localparam msg_state_t MSG_CLEAR = '{acc: 12'd0, pend: 4'd0, count: 7'd0, err: ST_OK};

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_done;
    status_t    status;
  } out_item_t;

  // base64url character to 6-bit value
  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t s;
    s.ok    = 1'b1;
    s.value = 6'd0;
    if (ch inside {[8'h41:8'h5A]}) begin
      s.value = 6'(ch - 8'h41);
    end else if (ch inside {[8'h61:8'h7A]}) begin
      s.value = 6'(ch - 8'h61) + LOWER_BASE;
    end else if (ch inside {[8'h30:8'h39]}) begin
      s.value = 6'(ch - 8'h30) + DIGIT_BASE;
    end else if (ch == 8'h2D) begin
      s.value = DASH_CODE;
    end else if (ch == 8'h5F) begin
      s.value = USCORE_CODE;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/b64d_in_if.sv @@
`default_nettype none

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       end_of_message;

  modport source (output valid, output char_code, output has_char, output end_of_message,
                  input ready);
  modport sink (input valid, input char_code, input has_char, input end_of_message,
                output ready);
endinterface

`default_nettype wire

@@ rtl/b64d_out_if.sv @@
`default_nettype none

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       message_done;
  logic [1:0] status;

  modport source (output valid, output data_byte, output byte_valid, output message_done,
                  output status, input ready);
  modport sink (input valid, input data_byte, input byte_valid, input message_done,
                input status, output ready);
endinterface

`default_nettype wire

@@ rtl/base64url_length_checked_decoder.sv @@
// base64url decoder (unpadded) with exact length check.
// char_in: one character per transfer (char_code, has_char, end_of_message).
// byte_out: at most one result per character: a decoded byte, the final
//   status on the end_of_message item, or both together.
// cfg_write/cfg_data set expected_bytes (saturated to 64); write it only
//   while no message is in flight.
// Path: a character taken goes into the input register, then through one
//   step of decode logic into the output register.
// Throughput: one character per cycle unless a result is held off; the
//   message state register, updated once per character, feeds straight back.
// Characters that yield no result leave the output register untouched.
// Reset: expected_bytes returns to 32, message state clears, both
//   registers empty.
// Stall: while byte_out is held off, the output register keeps its result
//   and one more character waits in the input register; then char_in.ready
//   drops. Characters that make no result still pass during a stall.
`default_nettype none

module base64url_length_checked_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  b64d_pkg::count_t    cfg_data,
  b64d_in_if.sink             char_in,
  b64d_out_if.source          byte_out
);
  import b64d_pkg::*;

  count_t     expected_bytes;
  count_t     limit;
  logic       in_valid;
  in_item_t   in_item;
  msg_state_t msg;
  msg_state_t msg_next;
  out_item_t  res;
  logic       produce;
  logic       in_advance;
  logic       out_valid;
  out_item_t  out_item;

  assign limit = (expected_bytes > MAX_LIMIT) ? MAX_LIMIT : expected_bytes;

  b64d_step u_step (
    .st      (msg),
    .item    (in_item),
    .limit   (limit),
    .st_next (msg_next),
    .res     (res),
    .produce (produce)
  );

  // Input register moves on unless its result is blocked
  assign in_advance   = in_valid && (!produce || !out_valid || byte_out.ready);
  assign char_in.ready = !in_valid || in_advance;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_bytes <= EXPECTED_RESET;
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
      msg            <= MSG_CLEAR;
    end else begin
      if (cfg_write) begin
        expected_bytes <= cfg_data;
      end
      if (char_in.ready) begin
        in_valid <= char_in.valid;
      end
      if (in_advance) begin
        msg <= msg_next;
      end
      if (in_advance && produce) begin
        out_valid <= 1'b1;
      end else if (out_valid && byte_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      in_item.char_code      <= char_in.char_code;
      in_item.has_char       <= char_in.has_char;
      in_item.end_of_message <= char_in.end_of_message;
    end
    if (in_advance && produce) begin
      out_item <= res;
    end
  end

  assign byte_out.valid        = out_valid;
  assign byte_out.data_byte    = out_item.data_byte;
  assign byte_out.byte_valid   = out_item.byte_valid;
  assign byte_out.message_done = out_item.message_done;
  assign byte_out.status       = out_item.status;

endmodule

`default_nettype wire

@@ rtl/b64d_step.sv @@
`default_nettype none

module b64d_step (
  input  b64d_pkg::msg_state_t st,
  input  b64d_pkg::in_item_t   item,
  input  b64d_pkg::count_t     limit,
  output b64d_pkg::msg_state_t st_next,
  output b64d_pkg::out_item_t  res,
  output logic                 produce
);
  import b64d_pkg::*;

  sextet_t     sx;
  logic [11:0] acc_shift;
  logic [3:0]  pend_sum;
  logic [3:0]  pend_left;
  logic        emit;
  logic [7:0]  byte_val;
  status_t     status;
  msg_state_t  st_upd;

  // One character: decode, accumulate, emit a byte once eight bits are held
  always_comb begin
    sx        = sextet_of(item.char_code);
    acc_shift = {st.acc[5:0], sx.value};
    pend_sum  = st.pend + 4'd6;
    pend_left = pend_sum - 4'd8;
    st_upd    = st;
    emit      = 1'b0;
    byte_val  = 8'd0;
    if (item.has_char && st.err == ST_OK) begin
      if (!sx.ok) begin
        st_upd.err = ST_BAD_CHAR;
      end else begin
        st_upd.acc = acc_shift;
        if (pend_sum >= 4'd8) begin
          st_upd.pend = pend_left;
          if (st.count >= limit) begin
            st_upd.err = ST_TOO_MANY;
          end else begin
            emit         = 1'b1;
            byte_val     = 8'(acc_shift >> pend_left);
            st_upd.count = st.count + 7'd1;
          end
        end else begin
          st_upd.pend = pend_sum;
        end
      end
    end
  end

  // Final status and message clear
  always_comb begin
    status = st_upd.err;
    if (item.end_of_message && status == ST_OK && st_upd.count != limit) begin
      status = ST_TOO_FEW;
    end
    res.data_byte    = byte_val;
    res.byte_valid   = emit;
    res.message_done = item.end_of_message;
    res.status       = status;
    produce          = emit || item.end_of_message;
    st_next          = item.end_of_message ? MSG_CLEAR : st_upd;
  end

endmodule

`default_nettype wire

@@ rtl/b64d_checker.sv @@
`default_nettype none
`include "base64url_length_checked_decoder_defines.svh"

module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] data_byte,
  input logic       byte_valid,
  input logic       message_done,
  input logic [1:0] status
);
  import b64d_pkg::*;

  // A stalled result holds
  `B64D_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(data_byte) && $stable(byte_valid) && $stable(message_done) && $stable(status), "result changed while stalled")

  // A result without a byte must close a message
  `B64D_ASSERT_NOW(a_empty_is_done, clk, rst, out_valid && !byte_valid, message_done && data_byte == 8'd0, "result without byte outside end of message")

  // Mid-message results are clean bytes
  `B64D_ASSERT_NOW(a_mid_ok, clk, rst, out_valid && !message_done, byte_valid && status == ST_OK, "error status before end of message")

endmodule

bind base64url_length_checked_decoder b64d_checker u_b64d_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (byte_out.valid),
  .out_ready    (byte_out.ready),
  .data_byte    (byte_out.data_byte),
  .byte_valid   (byte_out.byte_valid),
  .message_done (byte_out.message_done),
  .status       (byte_out.status)
);

`default_nettype wire

@@ sim/tb_base64url_length_checked_decoder.sv @@
`timescale 1ns / 100ps

module tb_base64url_length_checked_decoder;
  import b64d_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS  = 100;

  // Shapes of random message
  typedef enum int {
    MSG_EXACT,
    MSG_SHORT,
    MSG_LONG,
    MSG_BAD_CHAR,
    MSG_NOISE
  } msg_kind_t;

  logic   clk = 1'b0;
  logic   rst;
  logic   cfg_write;
  count_t cfg_data;

  b64d_in_if  char_in();
  b64d_out_if byte_out();

  base64url_length_checked_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .char_in  (char_in),
    .byte_out (byte_out)
  );

  // Clock: 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decoder model state and its copy of the length register
  logic [11:0] mdl_acc;
  logic [3:0]  mdl_pend;
  count_t      mdl_count;
  status_t     mdl_err;
  count_t      mdl_expected;

  out_item_t decoded_results_q[$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned chars_sent     = 0;
  int unsigned bytes_checked  = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  // Character to 6-bit value; returns 0 for anything outside the alphabet
  function automatic logic decode_sextet(input logic [7:0] ch, output logic [5:0] v);
    v = 6'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      v = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      v = 6'(ch - 8'h61) + LOWER_BASE;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      v = 6'(ch - 8'h30) + DIGIT_BASE;
    end else if (ch == 8'h2D) begin
      v = DASH_CODE;
    end else if (ch == 8'h5F) begin
      v = USCORE_CODE;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // 6-bit value to its character, for building well-formed messages
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < LOWER_BASE) return 8'h41 + 8'(v);
    if (v < DIGIT_BASE) return 8'h61 + 8'(v - LOWER_BASE);
    if (v < DASH_CODE) return 8'h30 + 8'(v - DIGIT_BASE);
    if (v == DASH_CODE) return 8'h2D;
    return 8'h5F;
  endfunction

  // Advance the model by one accepted character and queue the result it owes
  task automatic decode_predict(input logic [7:0] code, input logic has, input logic eom);
    count_t     lim;
    logic [5:0] v;
    logic       produced;
    logic [7:0] dec_byte;
    out_item_t  res;
    lim      = (mdl_expected > MAX_LIMIT) ? MAX_LIMIT : mdl_expected;
    produced = 1'b0;
    dec_byte = 8'd0;
    if (has && mdl_err == ST_OK) begin
      if (!decode_sextet(code, v)) begin
        mdl_err = ST_BAD_CHAR;
      end else begin
        mdl_acc  = {mdl_acc[5:0], v};
        mdl_pend = mdl_pend + 4'd6;
        if (mdl_pend >= 4'd8) begin
          mdl_pend = mdl_pend - 4'd8;
          if (mdl_count >= lim) begin
            mdl_err = ST_TOO_MANY;
          end else begin
            dec_byte  = 8'(mdl_acc >> mdl_pend);
            mdl_count = mdl_count + 7'd1;
            produced  = 1'b1;
          end
        end
      end
    end
    if (produced || eom) begin
      res.data_byte    = dec_byte;
      res.byte_valid   = produced;
      res.message_done = eom;
      res.status       = (eom && mdl_err == ST_OK && mdl_count != lim) ? ST_TOO_FEW : mdl_err;
      decoded_results_q = {decoded_results_q, res};
    end
    // end of message clears everything but the length register
    if (eom) begin
      mdl_acc   = 12'd0;
      mdl_pend  = 4'd0;
      mdl_count = 7'd0;
      mdl_err   = ST_OK;
    end
  endtask

  // Result checks first, then prediction of the character taken on this edge
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst) begin
      if (byte_out.valid && byte_out.ready) begin
        if (decoded_results_q.size() == 0) begin
          $error("unexpected result: data_byte %02h byte_valid %0b message_done %0b status %0d",
                 byte_out.data_byte, byte_out.byte_valid, byte_out.message_done,
                 byte_out.status);
          error_count++;
        end else begin
          want = decoded_results_q.pop_front();
          if (byte_out.data_byte !== want.data_byte) begin
            $error("data_byte: expected %02h, actual %02h", want.data_byte, byte_out.data_byte);
            error_count++;
          end
          if (byte_out.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, actual %0b", want.byte_valid,
                   byte_out.byte_valid);
            error_count++;
          end
          if (byte_out.message_done !== want.message_done) begin
            $error("message_done: expected %0b, actual %0b", want.message_done,
                   byte_out.message_done);
            error_count++;
          end
          if (byte_out.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, byte_out.status);
            error_count++;
          end
          if (want.byte_valid) bytes_checked++;
          if (want.message_done) status_seen[want.status]++;
        end
      end
      if (char_in.valid && char_in.ready) begin
        decode_predict(char_in.char_code, char_in.has_char, char_in.end_of_message);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    byte_out.ready <= ($urandom_range(1, 100) > sink_stall_pct);
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("run stopped after %0d cycles, %0d results outstanding", cycle_count,
             decoded_results_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One character transfer; valid stays high afterwards unless a gap follows
  task automatic send_char(input logic [7:0] code, input logic has, input logic eom);
    while (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
      char_in.valid <= 1'b0;
      @(posedge clk);
    end
    char_in.valid          <= 1'b1;
    char_in.char_code      <= code;
    char_in.has_char       <= has;
    char_in.end_of_message <= eom;
    @(posedge clk);
    while (!char_in.ready) @(posedge clk);
    if (has || eom) items_sent++;
    if (has) chars_sent++;
  endtask

  // Stop sending and wait until every owed result has been taken
  task automatic drain_decoder();
    char_in.valid <= 1'b0;
    @(posedge clk);
    while (decoded_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Length register write, only with the decoder idle
  task automatic write_expected(input count_t value);
    drain_decoder();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write    <= 1'b0;
    mdl_expected = value;
  endtask

  // Empty message against the reset length: too few bytes
  task automatic test_empty_at_reset();
    send_char(8'h41, 1'b0, 1'b1);
  endtask

  // Alphabet ends, byte and final status sharing one result
  task automatic test_alphabet_edges();
    write_expected(7'd3);
    send_char("A", 1'b1, 1'b0);
    send_char("Z", 1'b1, 1'b0);
    send_char("a", 1'b1, 1'b0);
    send_char("z", 1'b1, 1'b1);
  endtask

  // Too many, exact with an ignored item, and a limit above capacity
  task automatic test_length_errors();
    write_expected(7'd2);
    send_char("0", 1'b1, 1'b0);
    send_char("9", 1'b1, 1'b0);
    send_char("-", 1'b1, 1'b0);
    send_char("_", 1'b1, 1'b1);
    write_expected(7'd1);
    send_char("Q", 1'b1, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char("w", 1'b1, 1'b1);
    write_expected(7'd127);
    send_char(8'h00, 1'b0, 1'b1);
  endtask

  // Single-character messages around the alphabet edges, then a sticky error
  task automatic test_bad_characters();
    logic [7:0] probe[9] = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h2D, 8'h5F};
    write_expected(7'd0);
    foreach (probe[i]) send_char(probe[i], 1'b1, 1'b1);
    // standard base64 '+' is not base64url; the following character is dropped
    send_char("A", 1'b1, 1'b0);
    send_char(8'h2B, 1'b1, 1'b0);
    send_char("B", 1'b1, 1'b1);
  endtask

  // Mostly well-formed messages with random content, some broken, some noise
  task automatic test_random_messages(input int unsigned src_pct, input int unsigned snk_pct);
    int unsigned start;
    int unsigned r;
    int          n;
    int          exact_n;
    int          bad_pos;
    count_t      lim;
    count_t      value;
    msg_kind_t   kind;
    logic [7:0]  code;
    logic [5:0]  dummy;
    logic        eom_on_char;
    src_idle_pct   = src_pct;
    sink_stall_pct = snk_pct;
    start          = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      // new length now and then; long limits are rare and never kept
      if ($urandom_range(0, 1) == 0 || mdl_expected > 7'd16) begin
        r = $urandom_range(0, 47);
        case (r)
          0: value = MAX_LIMIT;
          1: value = ($urandom_range(0, 1) == 0) ? 7'd127 : count_t'($urandom_range(65, 126));
          2, 3, 4: value = 7'd0;
          5, 6, 7: value = 7'd1;
          default: value = count_t'($urandom_range(2, 9));
        endcase
        write_expected(value);
      end
      lim     = (mdl_expected > MAX_LIMIT) ? MAX_LIMIT : mdl_expected;
      exact_n = (4 * lim + 2) / 3;
      r       = $urandom_range(0, 9);
      case (r)
        6: kind = MSG_SHORT;
        7: kind = MSG_LONG;
        8: kind = MSG_BAD_CHAR;
        9: kind = MSG_NOISE;
        default: kind = MSG_EXACT;
      endcase
      case (kind)
        MSG_SHORT: n = (exact_n == 0) ? 0 : $urandom_range(0, exact_n - 1);
        MSG_LONG: n = exact_n + $urandom_range(1, 3);
        MSG_BAD_CHAR: n = (exact_n == 0) ? 1 : exact_n;
        MSG_NOISE: n = $urandom_range(0, 6);
        default: n = exact_n;
      endcase
      bad_pos     = $urandom_range(0, (n > 0) ? n - 1 : 0);
      eom_on_char = ($urandom_range(0, 1) == 1);
      for (int i = 0; i < n; i++) begin
        // empty transfer in the middle of the message
        if ($urandom_range(0, 7) == 0) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        if (kind == MSG_NOISE) begin
          code = 8'($urandom_range(0, 255));
        end else if (kind == MSG_BAD_CHAR && i == bad_pos) begin
          do code = 8'($urandom_range(0, 255)); while (decode_sextet(code, dummy));
        end else begin
          code = sextet_char(6'($urandom_range(0, 63)));
        end
        send_char(code, 1'b1, (i == n - 1) && eom_on_char);
      end
      // close with a characterless item; its code must be ignored
      if (n == 0 || !eom_on_char) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  initial begin
    rst                    <= 1'b1;
    cfg_write              <= 1'b0;
    cfg_data               <= '0;
    char_in.valid          <= 1'b0;
    char_in.char_code      <= 8'h00;
    char_in.has_char       <= 1'b0;
    char_in.end_of_message <= 1'b0;
    mdl_acc      = 12'd0;
    mdl_pend     = 4'd0;
    mdl_count    = 7'd0;
    mdl_err      = ST_OK;
    mdl_expected = EXPECTED_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_at_reset();
    test_alphabet_edges();
    test_length_errors();
    test_bad_characters();
    test_random_messages(0, 0);
    test_random_messages(69, 0);
    test_random_messages(0, 69);
    test_random_messages(32, 32);
    drain_decoder();

    $display("Sent %0d items (%0d characters) over many length settings and four idle mixes.",
             items_sent, chars_sent);
    $display("Checked %0d bytes; message endings ok %0d, bad char %0d, too many %0d, too few %0d.",
             bytes_checked, status_seen[ST_OK], status_seen[ST_BAD_CHAR],
             status_seen[ST_TOO_MANY], status_seen[ST_TOO_FEW]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
